### rtl/srkt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// srkt_pkg
// Shared types and codes for the sorted reference-count key table.
// ============================================================================
package srkt_pkg;

    localparam int KEY_PORT_W = 64;
    localparam int RSP_CNT_W  = 16;
    localparam int STATUS_W   = 2;

    localparam logic KIND_LOOKUP  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // sequencer phase strobes
    typedef struct packed {
        logic cmp;
        logic upd;
    } t_phase;

    // command broadcast to every cell
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
        logic inc;
        logic dec;
    } t_cmd;

endpackage

### rtl/srkt_if.sv
`timescale 1ns / 1ps
// ============================================================================
// srkt_req_if / srkt_rsp_if
// Valid/ready channels carrying request and response words.
// ============================================================================
interface srkt_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [srkt_pkg::KEY_PORT_W-1:0] key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface srkt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [srkt_pkg::RSP_CNT_W-1:0]  ref_count;
    logic                            removed;
    logic [srkt_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output hit, output ref_count, output removed,
                    output status, input ready);
    modport sink   (input valid, input hit, input ref_count, input removed,
                    input status, output ready);
endinterface

### rtl/srkt_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// srkt_cell
// One table slot: key, count and valid, with compare flags and neighbor shift.
// ============================================================================
module srkt_cell #(
    parameter int KEY_WIDTH   = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  srkt_pkg::t_cmd         i_cmd,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [KEY_WIDTH-1:0]   i_left_key,
    input  logic [COUNT_WIDTH-1:0] i_left_count,
    input  logic                   i_left_valid,
    input  logic                   i_left_after,
    input  logic [KEY_WIDTH-1:0]   i_right_key,
    input  logic [COUNT_WIDTH-1:0] i_right_count,
    input  logic                   i_right_valid,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_valid,
    output logic                   o_after,
    output logic                   o_eq,
    output logic [COUNT_WIDTH-1:0] o_tap
);

    logic [KEY_WIDTH-1:0]   r_key,   n_key;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_valid, n_valid;
    logic                   r_after, n_after;
    logic                   r_eq,    n_eq;

    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        n_valid = r_valid;
        n_after = r_after;
        n_eq    = r_eq;
        if (i_cmd.cmp) begin
            // empty slots count as above every key, keeping the flags a thermometer
            n_after = !r_valid || (r_key >= i_key);
            n_eq    = r_valid && (r_key == i_key);
        end
        if (i_cmd.ins && r_after) begin
            n_valid = i_left_valid;
            if (i_left_after) begin
                n_key   = i_left_key;
                n_count = i_left_count;
            end else begin
                n_key   = i_key;
                n_count = COUNT_WIDTH'(1);
            end
        end
        if (i_cmd.rem && r_after) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
            n_count = i_right_count;
        end
        if (i_cmd.inc && r_eq && (r_count != {COUNT_WIDTH{1'b1}})) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end
        if (i_cmd.dec && r_eq) begin
            n_count = r_count - COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_after <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_after <= n_after;
            r_eq    <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
    end

    assign o_key   = r_key;
    assign o_count = r_count;
    assign o_valid = r_valid;
    assign o_after = r_after;
    assign o_eq    = r_eq;
    assign o_tap   = r_eq ? r_count : '0;

endmodule

### rtl/srkt_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// srkt_seq
// Compare/update sequencer with request handshake.
// ============================================================================
module srkt_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_out_free,
    output logic             o_req_ready,
    output srkt_pkg::t_phase o_phase
);

    srkt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srkt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_phase     = '0;
        case (r_state)
            srkt_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) n_state = srkt_pkg::ST_CMP;
            end
            srkt_pkg::ST_CMP: begin
                o_phase.cmp = 1'b1;
                n_state     = srkt_pkg::ST_UPD;
            end
            srkt_pkg::ST_UPD: begin
                // hold until the result register can take the word
                if (i_out_free) begin
                    o_phase.upd = 1'b1;
                    o_req_ready = 1'b1;
                    n_state     = i_req_valid ? srkt_pkg::ST_CMP : srkt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srkt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/sorted_refcount_key_table.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_refcount_key_table
// Sorted key table with per-key reference counts, built as a chain of cells.
// ============================================================================
// Each request word passes a compare cycle and an update cycle: in the
// compare cycle every cell checks its stored key against the request key at
// once; in the update cycle the hit cell bumps its count, or the cells at
// and above the sorted place shift one slot up (insert) or down (removal)
// from their neighbors. The next request is accepted at the edge that closes
// the update cycle once the response register is free; a response that is
// not taken holds the block in its update cycle. Keys stay packed in cells
// 0 .. N-1 in ascending unsigned order, with a valid chain cleared by reset;
// there is no clearing pass. Only the low KEY_WIDTH bits of the key are
// used. Lookup of a present key increments its count (saturating); lookup of
// an absent key inserts it with count one, or reports full with the table
// untouched. Release decrements; at zero the entry is dropped and removed is
// set; release of an absent key reports absent. ref_count carries the low 16
// bits of the count after the step, zero on full or absent.
// ============================================================================
module sorted_refcount_key_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_WIDTH   = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srkt_req_if.sink   i_req,
    srkt_rsp_if.source o_rsp
);

    // request register
    logic                 r_kind;
    logic [KEY_WIDTH-1:0] r_key;

    // response register
    logic                               r_out_valid;
    logic                               r_hit;
    logic [srkt_pkg::RSP_CNT_W-1:0]     r_ref_count;
    logic                               r_removed;
    logic [srkt_pkg::STATUS_W-1:0]      r_status;

    logic             req_ready;
    logic             out_free;
    srkt_pkg::t_phase phase;
    srkt_pkg::t_cmd   cmd;

    // cell chain taps
    logic [KEY_WIDTH-1:0]   c_key   [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] c_count [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] c_tap   [TABLE_DEPTH];
    logic                   c_valid [TABLE_DEPTH];
    logic                   c_after [TABLE_DEPTH];
    logic                   c_eq    [TABLE_DEPTH];

    logic [KEY_WIDTH-1:0]   l_key   [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] l_count [TABLE_DEPTH];
    logic                   l_valid [TABLE_DEPTH];
    logic                   l_after [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]   r_nb_key   [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] r_nb_count [TABLE_DEPTH];
    logic                   r_nb_valid [TABLE_DEPTH];

    logic                   found;
    logic                   full;
    logic [COUNT_WIDTH-1:0] cnt_sel;
    logic [COUNT_WIDTH-1:0] cnt_res;
    logic [COUNT_WIDTH+srkt_pkg::RSP_CNT_W-1:0] cnt_ext;

    logic                            n_hit;
    logic                            n_removed;
    logic [srkt_pkg::STATUS_W-1:0]   n_status;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = req_ready;

    srkt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_out_free  (out_free),
        .o_req_ready (req_ready),
        .o_phase     (phase)
    );

    // capture the request word
    always_ff @(posedge i_clk) begin
        if (i_req.valid && req_ready) begin
            r_kind <= i_req.kind;
            r_key  <= i_req.key[KEY_WIDTH-1:0];
        end
    end

    // wire neighbors; the chain start acts as a valid slot below every key,
    // the chain end as an empty slot
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign l_key[g]   = '0;
            assign l_count[g] = '0;
            assign l_valid[g] = 1'b1;
            assign l_after[g] = 1'b0;
        end else begin : g_mid_l
            assign l_key[g]   = c_key[g-1];
            assign l_count[g] = c_count[g-1];
            assign l_valid[g] = c_valid[g-1];
            assign l_after[g] = c_after[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign r_nb_key[g]   = '0;
            assign r_nb_count[g] = '0;
            assign r_nb_valid[g] = 1'b0;
        end else begin : g_mid_r
            assign r_nb_key[g]   = c_key[g+1];
            assign r_nb_count[g] = c_count[g+1];
            assign r_nb_valid[g] = c_valid[g+1];
        end

        srkt_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_key         (r_key),
            .i_left_key    (l_key[g]),
            .i_left_count  (l_count[g]),
            .i_left_valid  (l_valid[g]),
            .i_left_after  (l_after[g]),
            .i_right_key   (r_nb_key[g]),
            .i_right_count (r_nb_count[g]),
            .i_right_valid (r_nb_valid[g]),
            .o_key         (c_key[g]),
            .o_count       (c_count[g]),
            .o_valid       (c_valid[g]),
            .o_after       (c_after[g]),
            .o_eq          (c_eq[g]),
            .o_tap         (c_tap[g])
        );
    end

    // gather the hit flag and the hit cell's count (at most one cell matches)
    always_comb begin
        found   = 1'b0;
        cnt_sel = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            found   = found | c_eq[i];
            cnt_sel = cnt_sel | c_tap[i];
        end
    end

    assign full = c_valid[TABLE_DEPTH-1];

    // decide the step and broadcast it to the chain
    always_comb begin
        cmd       = '0;
        cmd.cmp   = phase.cmp;
        n_hit     = 1'b0;
        n_removed = 1'b0;
        n_status  = srkt_pkg::STAT_OK;
        cnt_res   = '0;
        if (r_kind == srkt_pkg::KIND_LOOKUP) begin
            if (found) begin
                n_hit   = 1'b1;
                cmd.inc = phase.upd;
                cnt_res = (cnt_sel == {COUNT_WIDTH{1'b1}}) ? cnt_sel
                                                           : cnt_sel + COUNT_WIDTH'(1);
            end else if (full) begin
                n_status = srkt_pkg::STAT_FULL;
            end else begin
                cmd.ins = phase.upd;
                cnt_res = COUNT_WIDTH'(1);
            end
        end else begin
            if (!found) begin
                n_status = srkt_pkg::STAT_ABSENT;
            end else if (cnt_sel <= COUNT_WIDTH'(1)) begin
                // last reference: drop the entry
                n_hit     = 1'b1;
                n_removed = 1'b1;
                cmd.rem   = phase.upd;
            end else begin
                n_hit   = 1'b1;
                cmd.dec = phase.upd;
                cnt_res = cnt_sel - COUNT_WIDTH'(1);
            end
        end
    end

    assign cnt_ext = {{srkt_pkg::RSP_CNT_W{1'b0}}, cnt_res};

    // response register: load on update, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (phase.upd) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (phase.upd) begin
            r_hit       <= n_hit;
            r_ref_count <= cnt_ext[srkt_pkg::RSP_CNT_W-1:0];
            r_removed   <= n_removed;
            r_status    <= n_status;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_hit;
    assign o_rsp.ref_count = r_ref_count;
    assign o_rsp.removed   = r_removed;
    assign o_rsp.status    = r_status;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking regression for the sorted reference-count key table.
// ============================================================================
// A scoreboard class keeps a software image of the sorted table. It predicts
// one response for every request word the block accepts and checks each
// response word against the oldest prediction. Stimulus begins with
// directed words for the ordering extremes and every insert or removal
// position. Random phases follow: mixes over small key pools, a fill past
// capacity, full-range noise, and a run of repeated lookups that piles
// references onto one key. Both channels idle at random. The receiver holds
// off once for a long stretch, and the sender pauses for drains between
// phases.
// ============================================================================
module testbench;

    localparam int          TABLE_CELLS   = 64;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          HOLDOFF_LEN   = 400;
    localparam int          SAT_LOOKUPS   = 50;

    typedef struct packed {
        logic                           hit;
        logic [srkt_pkg::RSP_CNT_W-1:0] ref_count;
        logic                           removed;
        logic [srkt_pkg::STATUS_W-1:0]  status;
    } t_reply;

    // ------------------------------------------------------------------------
    // Scoreboard: sorted table image plus the queue of predicted responses.
    // ------------------------------------------------------------------------
    class refcount_scoreboard;
        logic [srkt_pkg::KEY_PORT_W-1:0] cell_key[TABLE_CELLS];
        logic [15:0]                     cell_count[TABLE_CELLS];
        int                              used;
        t_reply                          predicted[$];
        int                              mismatches;
        int                              responses;
        int                              n_requests, n_hits, n_inserts, n_removed;
        int                              n_full, n_absent, n_saturated;

        function new();
            used = 0;
            mismatches = 0;
            responses = 0;
            n_requests = 0;
            n_hits = 0;
            n_inserts = 0;
            n_removed = 0;
            n_full = 0;
            n_absent = 0;
            n_saturated = 0;
        endfunction

        function int pending();
            return predicted.size();
        endfunction

        function int entries();
            return used;
        endfunction

        function logic [srkt_pkg::KEY_PORT_W-1:0] any_key();
            if (used == 0) return '0;
            return cell_key[$urandom_range(used - 1)];
        endfunction

        // Apply one accepted request word to the image and queue its response.
        function void note_request(logic kind, logic [srkt_pkg::KEY_PORT_W-1:0] key);
            int     pos;
            bit     found;
            t_reply r;
            pos = 0;
            r = '0;
            while (pos < used && cell_key[pos] < key) pos++;
            found = (pos < used) && (cell_key[pos] == key);
            n_requests++;
            if (kind == srkt_pkg::KIND_LOOKUP) begin
                if (found) begin
                    if (cell_count[pos] != COUNT_MAX) cell_count[pos]++;
                    else n_saturated++;
                    r.hit = 1'b1;
                    r.ref_count = cell_count[pos];
                    n_hits++;
                end else if (used >= TABLE_CELLS) begin
                    r.status = srkt_pkg::STAT_FULL;
                    n_full++;
                end else begin
                    for (int i = used; i > pos; i--) begin
                        cell_key[i] = cell_key[i-1];
                        cell_count[i] = cell_count[i-1];
                    end
                    cell_key[pos] = key;
                    cell_count[pos] = 16'd1;
                    used++;
                    r.ref_count = 16'd1;
                    n_inserts++;
                end
            end else begin
                if (!found) begin
                    r.status = srkt_pkg::STAT_ABSENT;
                    n_absent++;
                end else begin
                    r.hit = 1'b1;
                    if (cell_count[pos] != 16'd0) cell_count[pos]--;
                    r.ref_count = cell_count[pos];
                    if (cell_count[pos] == 16'd0) begin
                        for (int i = pos; i + 1 < used; i++) begin
                            cell_key[i] = cell_key[i+1];
                            cell_count[i] = cell_count[i+1];
                        end
                        used--;
                        r.removed = 1'b1;
                        n_removed++;
                    end
                end
            end
            predicted.push_back(r);
        endfunction

        // Compare one accepted response word with the oldest prediction.
        function void check_response(t_reply got);
            t_reply want;
            responses++;
            if (predicted.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("response %0d arrived with no request outstanding",
                             responses);
                return;
            end
            want = predicted.pop_front();
            if (got.hit !== want.hit || got.ref_count !== want.ref_count ||
                got.removed !== want.removed || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"response %0d mismatch: expected hit=%0b count=%0d ",
                              "removed=%0b status=%0d, got hit=%0b count=%0d ",
                              "removed=%0b status=%0d"},
                             responses, want.hit, want.ref_count, want.removed,
                             want.status, got.hit, got.ref_count, got.removed,
                             got.status);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block under test.
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    srkt_req_if req_ch ();
    srkt_rsp_if rsp_ch ();

    sorted_refcount_key_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    refcount_scoreboard              sb;
    bit                              calm;          // suppress random idling on both sides
    int                              stall_request; // hold-off length handed to the receiver
    int                              stall_left;
    logic [srkt_pkg::KEY_PORT_W-1:0] key_pool[80];

    // ------------------------------------------------------------------------
    // Receiver: take response words, idle at random, honor a hold-off.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response({rsp_ch.hit, rsp_ch.ref_count, rsp_ch.removed,
                                   rsp_ch.status});
            if (stall_request > 0) begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= calm || ($urandom_range(99) >= 14);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks.
    // ------------------------------------------------------------------------
    // Offer one request word, with an occasional idle gap ahead of it, and
    // hold it until the block takes it. Note the word at the accepting edge.
    task automatic send_word(input logic kind,
                             input logic [srkt_pkg::KEY_PORT_W-1:0] key);
        int gap;
        gap = (!calm && $urandom_range(99) < 25) ? $urandom_range(2, 1) : 0;
        repeat (gap) begin
            req_ch.valid <= 1'b0;
            req_ch.kind  <= 1'($urandom);
            req_ch.key   <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.key   <= key;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(kind, key);
    endtask

    // Drop valid and hold off until every predicted response has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random lookups and releases over the first pool_n pool keys, with a
    // sprinkle of full-range keys.
    task automatic run_pool_mix(input int n_words, input int pool_n,
                                input int lookup_pct);
        logic                            kind;
        logic [srkt_pkg::KEY_PORT_W-1:0] key;
        repeat (n_words) begin
            kind = ($urandom_range(99) < lookup_pct) ? srkt_pkg::KIND_LOOKUP
                                                     : srkt_pkg::KIND_RELEASE;
            if ($urandom_range(99) < 5) key = {$urandom, $urandom};
            else key = key_pool[$urandom_range(pool_n - 1)];
            send_word(kind, key);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [srkt_pkg::KEY_PORT_W-1:0] base;
        logic [srkt_pkg::KEY_PORT_W-1:0] sat_key;
        int                              guard;

        sb = new();
        calm = 1'b0;
        stall_request = 0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= srkt_pkg::KIND_LOOKUP;
        req_ch.key   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table release, inserts at front, back and middle,
        // hits, and removals from the middle, the front and the back.
        send_word(srkt_pkg::KIND_RELEASE, 64'h0);
        send_word(srkt_pkg::KIND_LOOKUP,  64'h0);
        send_word(srkt_pkg::KIND_LOOKUP,  64'hFFFF_FFFF_FFFF_FFFF);
        send_word(srkt_pkg::KIND_LOOKUP,  64'h8000_0000_0000_0000);
        send_word(srkt_pkg::KIND_LOOKUP,  64'h7FFF_FFFF_FFFF_FFFF);
        send_word(srkt_pkg::KIND_LOOKUP,  64'h0);
        send_word(srkt_pkg::KIND_LOOKUP,  64'h8000_0000_0000_0000);
        send_word(srkt_pkg::KIND_RELEASE, 64'h8000_0000_0000_0000);
        send_word(srkt_pkg::KIND_RELEASE, 64'h8000_0000_0000_0000);
        send_word(srkt_pkg::KIND_RELEASE, 64'h8000_0000_0000_0000);
        send_word(srkt_pkg::KIND_RELEASE, 64'h0);
        send_word(srkt_pkg::KIND_RELEASE, 64'h0);
        send_word(srkt_pkg::KIND_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(srkt_pkg::KIND_RELEASE, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(srkt_pkg::KIND_LOOKUP,  64'hAAAA_AAAA_AAAA_AAAA);
        send_word(srkt_pkg::KIND_LOOKUP,  64'h5555_5555_5555_5555);
        send_word(srkt_pkg::KIND_LOOKUP,  64'hFFFF_FFFF_FFFF_FFFE);
        send_word(srkt_pkg::KIND_LOOKUP,  64'h0000_0000_0000_0001);
        send_word(srkt_pkg::KIND_LOOKUP,  64'h5555_5555_5555_5555);
        send_word(srkt_pkg::KIND_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(srkt_pkg::KIND_RELEASE, 64'h0000_0000_0000_0001);
        send_word(srkt_pkg::KIND_RELEASE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_word(srkt_pkg::KIND_RELEASE, 64'h5555_5555_5555_5555);
        send_word(srkt_pkg::KIND_RELEASE, 64'h5555_5555_5555_5555);
        wait_drained();

        // Small pool with both extremes; open with a long receiver hold-off
        // while the sender keeps offering, so the input side backs up.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 24; i++) key_pool[i] = {$urandom, $urandom};
        stall_request = HOLDOFF_LEN;
        run_pool_mix(500, 24, 60);
        wait_drained();

        // Fill past capacity so lookups of new keys are refused, then release
        // until the table is empty again.
        for (int i = 0; i < 80; i++) key_pool[i] = {$urandom, $urandom};
        run_pool_mix(300, 80, 85);
        guard = 0;
        while (sb.entries() > 0 && guard < 4000) begin
            send_word(srkt_pkg::KIND_RELEASE, sb.any_key());
            guard++;
        end
        wait_drained();

        // Keys that each differ from one base in a single bit stress the ordering compare; run without idling.
        base = {$urandom, $urandom};
        for (int i = 0; i < 40; i++)
            key_pool[i] = base ^ (64'd1 << $urandom_range(63));
        calm = 1'b1;
        run_pool_mix(400, 40, 55);
        wait_drained();
        calm = 1'b0;

        // Full-range noise on both kinds.
        repeat (200) send_word(1'($urandom), {$urandom, $urandom});
        wait_drained();

        // Pile references onto one present key, then step back down.
        if (sb.entries() == 0) send_word(srkt_pkg::KIND_LOOKUP, {$urandom, $urandom});
        sat_key = sb.any_key();
        repeat (SAT_LOOKUPS) send_word(srkt_pkg::KIND_LOOKUP, sat_key);
        repeat (3) send_word(srkt_pkg::KIND_RELEASE, sat_key);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests: %0d hits, %0d inserts, %0d removals",
                 sb.n_requests, sb.n_hits, sb.n_inserts, sb.n_removed);
        $display("  plus %0d full refusals, %0d absent releases, %0d held at max count",
                 sb.n_full, sb.n_absent, sb.n_saturated);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("sorted_refcount_key_table regression: pass");
        end else begin
            $display("%0d mismatches, %0d responses missing", sb.mismatches,
                     sb.pending());
            $display("sorted_refcount_key_table regression: fail");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #20_000_000;
        $display("timeout with %0d responses outstanding", sb.pending());
        $display("sorted_refcount_key_table regression: fail");
        $finish;
    end

endmodule

### files.f
rtl/srkt_pkg.sv
rtl/srkt_if.sv
rtl/srkt_cell.sv
rtl/srkt_seq.sv
rtl/sorted_refcount_key_table.sv
verif/testbench.sv
